### rtl/mbrtu_pkg.sv
// Shared codes, types and the CRC-16 byte step for the Modbus RTU slave.
`default_nettype none
package mbrtu_pkg;

  // host-side operation codes
  localparam logic [2:0] OP_RX_BYTE    = 3'd0;
  localparam logic [2:0] OP_FRAME_END  = 3'd1;
  localparam logic [2:0] OP_LOAD_INPUT = 3'd2;
  localparam logic [2:0] OP_LOAD_DISC  = 3'd3;
  localparam logic [2:0] OP_READ_HOLD  = 3'd4;
  localparam logic [2:0] OP_READ_COIL  = 3'd5;

  // configuration register indexes
  localparam logic [2:0] CFG_SLAVE_ADDR = 3'd0;
  localparam logic [2:0] CFG_HOLD_CNT   = 3'd1;
  localparam logic [2:0] CFG_INPUT_CNT  = 3'd2;
  localparam logic [2:0] CFG_COIL_CNT   = 3'd3;
  localparam logic [2:0] CFG_DISC_CNT   = 3'd4;
  localparam logic [2:0] CFG_TRIG_CODE  = 3'd5;
  localparam logic [2:0] CFG_TRIG_MAGIC = 3'd6;

  // Modbus function codes
  localparam logic [7:0] FN_RD_COILS  = 8'd1;
  localparam logic [7:0] FN_RD_DISC   = 8'd2;
  localparam logic [7:0] FN_RD_HOLD   = 8'd3;
  localparam logic [7:0] FN_RD_INPUT  = 8'd4;
  localparam logic [7:0] FN_WR_COIL   = 8'd5;
  localparam logic [7:0] FN_WR_REG    = 8'd6;
  localparam logic [7:0] FN_WR_COILS  = 8'd15;
  localparam logic [7:0] FN_WR_REGS   = 8'd16;

  // exception codes
  localparam logic [7:0] EXC_ILLEGAL_FN    = 8'd1;
  localparam logic [7:0] EXC_ILLEGAL_ADDR  = 8'd2;
  localparam logic [7:0] EXC_ILLEGAL_VALUE = 8'd3;

  // response kinds
  localparam logic [2:0] RSP_NONE  = 3'd0;
  localparam logic [2:0] RSP_EXC   = 3'd1;
  localparam logic [2:0] RSP_BOOT  = 3'd2;
  localparam logic [2:0] RSP_ECHO6 = 3'd3;
  localparam logic [2:0] RSP_ECHO8 = 3'd4;
  localparam logic [2:0] RSP_RREGS = 3'd5;
  localparam logic [2:0] RSP_RBITS = 3'd6;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  EXC_FLAG = 8'h80;
  localparam logic [7:0]  COIL_ON  = 8'hFF;
  localparam int unsigned TX_LIMIT = 128;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    logic       boot;
  } tx_byte_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] value;
  } host_rd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/mbrtu_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none
module mbrtu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### rtl/mbrtu_txpack.sv
// Packs response bytes in pairs, or passes a host read value, and holds the result register toward the output.
`default_nettype none
module mbrtu_txpack
  import mbrtu_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire tx_byte_t    byte_i,
  input  wire host_rd_t    host_i,
  input  wire logic [15:0] err_i,
  output logic             slot_free_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [15:0] tx_word_o,
  output logic      [1:0]  tx_count_o,
  output logic             tx_last_o,
  output logic      [15:0] host_read_value_o,
  output logic      [15:0] error_total_o,
  output logic             bootloader_request_o
);

  logic        vld_q, vld_d;
  logic        has_q, has_d;
  logic [7:0]  hi_q, hi_d;
  logic [15:0] word_q, word_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        last_q, last_d;
  logic [15:0] hval_q, hval_d;
  logic [15:0] err_q, err_d;
  logic        boot_q, boot_d;
  logic        free;

  assign free = !vld_q || out_ready_i;

  always_comb begin
    vld_d  = free ? 1'b0 : vld_q;
    has_d  = has_q;
    hi_d   = hi_q;
    word_d = word_q;
    cnt_d  = cnt_q;
    last_d = last_q;
    hval_d = hval_q;
    err_d  = err_q;
    boot_d = boot_q;
    if (free && byte_i.valid) begin
      if (has_q || byte_i.last) begin
        vld_d  = 1'b1;
        has_d  = 1'b0;
        word_d = has_q ? {hi_q, byte_i.data} : {byte_i.data, 8'h00};
        cnt_d  = has_q ? 2'd2 : 2'd1;
        last_d = byte_i.last;
        boot_d = byte_i.last && byte_i.boot;
        hval_d = 16'h0000;
        err_d  = err_i;
      end else begin
        has_d = 1'b1;
        hi_d  = byte_i.data;
      end
    end else if (free && host_i.valid) begin
      vld_d  = 1'b1;
      word_d = 16'h0000;
      cnt_d  = 2'd0;
      last_d = 1'b0;
      boot_d = 1'b0;
      hval_d = host_i.value;
      err_d  = err_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      has_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      has_q <= has_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q   <= hi_d;
    word_q <= word_d;
    cnt_q  <= cnt_d;
    last_q <= last_d;
    hval_q <= hval_d;
    err_q  <= err_d;
    boot_q <= boot_d;
  end

  assign slot_free_o          = free;
  assign out_valid_o          = vld_q;
  assign tx_word_o            = word_q;
  assign tx_count_o           = cnt_q;
  assign tx_last_o            = last_q;
  assign host_read_value_o    = hval_q;
  assign error_total_o        = err_q;
  assign bootloader_request_o = boot_q;

endmodule
`default_nettype wire

### rtl/modbus_rtu_slave_engine_unit.sv
// Modbus RTU slave: frame buffer, register stores, request sequencer and response output.
// Bytes and host loads are taken while idle; a host read's result is registered in the packer.
// A frame end scans max(n,8) buffer bytes, then emits one response byte per cycle while the
// packer has a free slot; bit reads gather each byte bit by bit and register reads fetch each
// register before sending it. After reset the stores are swept to zero with input held off.
`default_nettype none
module modbus_rtu_slave_engine_unit
  import mbrtu_pkg::*;
#(
  parameter int unsigned FRAME_BYTES    = 128,
  parameter int unsigned HOLDING_DEPTH  = 64,
  parameter int unsigned INPUT_DEPTH    = 64,
  parameter int unsigned COIL_DEPTH     = 256,
  parameter int unsigned DISCRETE_DEPTH = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  operation_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [7:0]  local_address_i,
  input  wire logic [15:0] local_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [15:0] tx_word_o,
  output logic      [1:0]  tx_count_o,
  output logic             tx_last_o,
  output logic      [15:0] host_read_value_o,
  output logic      [15:0] error_total_o,
  output logic             bootloader_request_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned HAW = (HOLDING_DEPTH > 1) ? $clog2(HOLDING_DEPTH) : 1;
  localparam int unsigned IAW = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;
  localparam int unsigned CAW = (COIL_DEPTH > 1) ? $clog2(COIL_DEPTH) : 1;
  localparam int unsigned DAW = (DISCRETE_DEPTH > 1) ? $clog2(DISCRETE_DEPTH) : 1;
  localparam int unsigned RAW = $clog2(FRAME_BYTES);
  localparam int unsigned RLW = $clog2(FRAME_BYTES + 1);
  localparam int unsigned MAXD01 = (HOLDING_DEPTH > INPUT_DEPTH) ? HOLDING_DEPTH : INPUT_DEPTH;
  localparam int unsigned MAXD23 = (COIL_DEPTH > DISCRETE_DEPTH) ? COIL_DEPTH : DISCRETE_DEPTH;
  localparam int unsigned MAXD = (MAXD01 > MAXD23) ? MAXD01 : MAXD23;
  localparam int unsigned CLW = $clog2(MAXD + 1);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_HREAD  = 4'd2;
  localparam logic [3:0] ST_SCAN   = 4'd3;
  localparam logic [3:0] ST_DECIDE = 4'd4;
  localparam logic [3:0] ST_WR16   = 4'd5;
  localparam logic [3:0] ST_HDR    = 4'd6;
  localparam logic [3:0] ST_RRD    = 4'd7;
  localparam logic [3:0] ST_RHI    = 4'd8;
  localparam logic [3:0] ST_RLO    = 4'd9;
  localparam logic [3:0] ST_BRD    = 4'd10;
  localparam logic [3:0] ST_BEMIT  = 4'd11;
  localparam logic [3:0] ST_TXCRC  = 4'd12;

  function automatic logic [16:0] lim17(input logic [16:0] c, input logic [16:0] d);
    return (c < d) ? c : d;
  endfunction

  // control and configuration registers
  logic [3:0]     state_q, state_d;
  logic [CLW-1:0] clr_q, clr_d;
  logic [7:0]     sa_q, sa_d, tcode_q, tcode_d;
  logic [6:0]     hcnt_q, hcnt_d, icnt_q, icnt_d;
  logic [8:0]     ccnt_q, ccnt_d, dcnt_q, dcnt_d;
  logic [15:0]    magic_q, magic_d;
  logic [RLW-1:0] rxlen_q, rxlen_d;
  logic           ovf_q, ovf_d;
  logic [15:0]    err_q, err_d;
  logic           pv_q, pv_d;

  // sequencer payload registers
  logic [RLW-1:0] n_q, n_d, ri_q, ri_d, rend_q, rend_d, pj_q, pj_d;
  logic [15:0]    crc_q, crc_d, txcrc_q, txcrc_d;
  logic [7:0]     f_q [8];
  logic [7:0]     f_d [8];
  logic [7:0]     fl2_q, fl2_d, fl1_q, fl1_d;
  logic [2:0]     kind_q, kind_d;
  logic [7:0]     code_q, code_d;
  logic           hv_q, hv_d, hsel_q, hsel_d;
  logic [2:0]     h_q, h_d;
  logic [7:0]     k_q, k_d, nb_q, nb_d, db_q, db_d, hi_q, hi_d;
  logic [3:0]     j_q, j_d;
  logic           bpv_q, bpv_d, c_q, c_d;

  // memory ports
  logic           rx_we, rx_re;
  logic [RAW-1:0] rx_wa, rx_ra;
  logic [7:0]     rx_wd, rx_rd;
  logic           hs_we, hs_re;
  logic [HAW-1:0] hs_wa, hs_ra;
  logic [15:0]    hs_wd, hs_rd;
  logic           is_we, is_re;
  logic [IAW-1:0] is_wa, is_ra;
  logic [15:0]    is_wd, is_rd;
  logic           cs_we, cs_re;
  logic [CAW-1:0] cs_wa, cs_ra;
  logic [0:0]     cs_wd, cs_rd;
  logic           ds_we, ds_re;
  logic [DAW-1:0] ds_wa, ds_ra;
  logic [0:0]     ds_wd, ds_rd;

  tx_byte_t tb;
  host_rd_t hr;
  logic     slot_free;
  logic     tx_acc;

  // frame decode
  logic [15:0] start16, qty16;
  logic [16:0] st17, q17, end17, nb17, hc17, ic17, cc17, dc17, cnt17, n17;
  logic        crc_ok, bc;
  logic        d_err, d_coilwr, d_holdwr, d_wr16;
  logic [2:0]  d_kind;
  logic [7:0]  d_code;
  logic [2:0]  hlen;
  logic [7:0]  hbyte;
  logic [15:0] off16, rreg;
  logic [RLW-1:0] rel;

  assign start16 = {f_q[2], f_q[3]};
  assign qty16   = {f_q[4], f_q[5]};
  assign st17    = {1'b0, start16};
  assign q17     = {1'b0, qty16};
  assign end17   = st17 + q17;
  assign nb17    = (qty16 == 16'h0000) ? 17'd1 : ((q17 + 17'd7) >> 3);
  assign n17     = 17'(n_q);
  assign hc17    = lim17(17'(hcnt_q), 17'(HOLDING_DEPTH));
  assign ic17    = lim17(17'(icnt_q), 17'(INPUT_DEPTH));
  assign cc17    = lim17(17'(ccnt_q), 17'(COIL_DEPTH));
  assign dc17    = lim17(17'(dcnt_q), 17'(DISCRETE_DEPTH));
  assign crc_ok  = (fl2_q == crc_q[7:0]) && (fl1_q == crc_q[15:8]);
  assign bc      = (f_q[0] == 8'h00);
  assign off16   = {5'b0, k_q, 3'b000} + {12'h000, j_q};
  assign rreg    = (f_q[1] == FN_RD_HOLD) ? hs_rd : is_rd;
  assign rel     = pj_q - RLW'(7);

  always_comb begin
    d_err    = 1'b0;
    d_kind   = RSP_NONE;
    d_code   = EXC_ILLEGAL_FN;
    d_coilwr = 1'b0;
    d_holdwr = 1'b0;
    d_wr16   = 1'b0;
    cnt17    = 17'd0;
    if (n_q == RLW'(6)) begin
      if (f_q[0] != sa_q) begin
        d_kind = RSP_NONE;
      end else if (!crc_ok || f_q[1] != tcode_q) begin
        d_err = 1'b1;
      end else if ({f_q[2], f_q[3]} != magic_q) begin
        d_err  = 1'b1;
        d_kind = RSP_EXC;
        d_code = EXC_ILLEGAL_VALUE;
      end else begin
        d_kind = RSP_BOOT;
      end
    end else if (!bc && f_q[0] != sa_q) begin
      d_kind = RSP_NONE;
    end else if (!crc_ok) begin
      d_err = 1'b1;
    end else begin
      case (f_q[1])
        FN_RD_COILS, FN_RD_DISC: begin
          cnt17 = (f_q[1] == FN_RD_COILS) ? cc17 : dc17;
          d_err = 1'b1;
          if (bc) begin
            d_code = EXC_ILLEGAL_FN;
          end else if (st17 >= cnt17) begin
            d_kind = RSP_EXC;
            d_code = EXC_ILLEGAL_ADDR;
          end else if (end17 > cnt17 || (17'd5 + nb17) > 17'(TX_LIMIT)) begin
            d_kind = RSP_EXC;
            d_code = EXC_ILLEGAL_VALUE;
          end else begin
            d_err  = 1'b0;
            d_kind = RSP_RBITS;
          end
        end
        FN_RD_HOLD, FN_RD_INPUT: begin
          cnt17 = (f_q[1] == FN_RD_HOLD) ? hc17 : ic17;
          d_err = 1'b1;
          if (bc) begin
            d_code = EXC_ILLEGAL_FN;
          end else if (st17 >= cnt17) begin
            d_kind = RSP_EXC;
            d_code = EXC_ILLEGAL_ADDR;
          end else if (end17 > cnt17 || (17'd5 + (q17 << 1)) > 17'(TX_LIMIT)) begin
            d_kind = RSP_EXC;
            d_code = EXC_ILLEGAL_VALUE;
          end else begin
            d_err  = 1'b0;
            d_kind = RSP_RREGS;
          end
        end
        FN_WR_COIL: begin
          if (bc) begin
            d_err = 1'b1;
          end else if (st17 < cc17) begin
            d_coilwr = 1'b1;
            d_kind   = RSP_ECHO8;
          end else begin
            d_err  = 1'b1;
            d_kind = RSP_EXC;
            d_code = EXC_ILLEGAL_ADDR;
          end
        end
        FN_WR_REG: begin
          if (st17 < hc17) begin
            d_holdwr = 1'b1;
            d_kind   = bc ? RSP_NONE : RSP_ECHO6;
          end else begin
            d_err  = 1'b1;
            d_kind = bc ? RSP_NONE : RSP_EXC;
            d_code = EXC_ILLEGAL_ADDR;
          end
        end
        FN_WR_COILS: begin
          if (bc) begin
            d_err = 1'b1;
          end else if (st17 < cc17) begin
            d_kind = RSP_ECHO6;
          end else begin
            d_err  = 1'b1;
            d_kind = RSP_EXC;
            d_code = EXC_ILLEGAL_ADDR;
          end
        end
        FN_WR_REGS: begin
          if ((17'(f_q[6]) + 17'd9) != n17) begin
            d_err = 1'b1;
          end else if (st17 >= hc17) begin
            d_err  = 1'b1;
            d_kind = bc ? RSP_NONE : RSP_EXC;
            d_code = EXC_ILLEGAL_ADDR;
          end else if (end17 > hc17 || 17'(f_q[6]) != (q17 << 1)) begin
            d_err  = 1'b1;
            d_kind = bc ? RSP_NONE : RSP_EXC;
            d_code = EXC_ILLEGAL_VALUE;
          end else begin
            d_wr16 = 1'b1;
            d_kind = bc ? RSP_NONE : RSP_ECHO6;
          end
        end
        default: begin
          d_err  = 1'b1;
          d_kind = bc ? RSP_NONE : RSP_EXC;
          d_code = EXC_ILLEGAL_FN;
        end
      endcase
    end
  end

  // header bytes of each response kind
  always_comb begin
    hlen  = 3'd2;
    hbyte = 8'h00;
    case (kind_q)
      RSP_EXC: begin
        hlen = 3'd2;
        case (h_q)
          3'd0:    hbyte = sa_q;
          3'd1:    hbyte = f_q[1] | EXC_FLAG;
          default: hbyte = code_q;
        endcase
      end
      RSP_BOOT: begin
        hlen = 3'd3;
        case (h_q)
          3'd0:    hbyte = sa_q;
          3'd1:    hbyte = tcode_q;
          default: hbyte = 8'h00;
        endcase
      end
      RSP_ECHO6: begin
        hlen  = 3'd5;
        hbyte = f_q[h_q];
      end
      RSP_ECHO8: begin
        hlen  = 3'd7;
        hbyte = f_q[h_q];
      end
      RSP_RREGS, RSP_RBITS: begin
        hlen = 3'd2;
        case (h_q)
          3'd0:    hbyte = sa_q;
          3'd1:    hbyte = f_q[1];
          default: hbyte = (kind_q == RSP_RREGS) ? {qty16[6:0], 1'b0} : nb_q;
        endcase
      end
      default: begin
        hlen  = 3'd2;
        hbyte = 8'h00;
      end
    endcase
  end

  // response byte toward the packer
  always_comb begin
    tb       = '0;
    tb.boot  = (kind_q == RSP_BOOT);
    case (state_q)
      ST_HDR: begin
        tb.valid = 1'b1;
        tb.data  = hbyte;
        tb.last  = (kind_q == RSP_ECHO8) && (h_q == hlen);
      end
      ST_RHI: begin
        tb.valid = 1'b1;
        tb.data  = rreg[15:8];
      end
      ST_RLO: begin
        tb.valid = 1'b1;
        tb.data  = rreg[7:0];
      end
      ST_BEMIT: begin
        tb.valid = 1'b1;
        tb.data  = db_q;
      end
      ST_TXCRC: begin
        tb.valid = 1'b1;
        tb.data  = c_q ? txcrc_q[15:8] : txcrc_q[7:0];
        tb.last  = c_q;
      end
      default: tb.valid = 1'b0;
    endcase
  end

  assign tx_acc = tb.valid && slot_free;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    sa_d    = sa_q;
    tcode_d = tcode_q;
    hcnt_d  = hcnt_q;
    icnt_d  = icnt_q;
    ccnt_d  = ccnt_q;
    dcnt_d  = dcnt_q;
    magic_d = magic_q;
    rxlen_d = rxlen_q;
    ovf_d   = ovf_q;
    err_d   = err_q;
    pv_d    = 1'b0;
    n_d     = n_q;
    ri_d    = ri_q;
    rend_d  = rend_q;
    pj_d    = ri_q;
    crc_d   = crc_q;
    txcrc_d = txcrc_q;
    f_d     = f_q;
    fl2_d   = fl2_q;
    fl1_d   = fl1_q;
    kind_d  = kind_q;
    code_d  = code_q;
    hv_d    = hv_q;
    hsel_d  = hsel_q;
    h_d     = h_q;
    k_d     = k_q;
    nb_d    = nb_q;
    db_d    = db_q;
    hi_d    = hi_q;
    j_d     = j_q;
    bpv_d   = bpv_q;
    c_d     = c_q;
    in_ready_o = 1'b0;
    hr      = '0;
    rx_we = 1'b0; rx_wa = '0; rx_wd = '0; rx_re = 1'b0; rx_ra = '0;
    hs_we = 1'b0; hs_wa = '0; hs_wd = '0; hs_re = 1'b0; hs_ra = '0;
    is_we = 1'b0; is_wa = '0; is_wd = '0; is_re = 1'b0; is_ra = '0;
    cs_we = 1'b0; cs_wa = '0; cs_wd = '0; cs_re = 1'b0; cs_ra = '0;
    ds_we = 1'b0; ds_wa = '0; ds_wd = '0; ds_re = 1'b0; ds_ra = '0;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SLAVE_ADDR: sa_d    = cfg_data_i[7:0];
        CFG_HOLD_CNT:   hcnt_d  = cfg_data_i[6:0];
        CFG_INPUT_CNT:  icnt_d  = cfg_data_i[6:0];
        CFG_COIL_CNT:   ccnt_d  = cfg_data_i[8:0];
        CFG_DISC_CNT:   dcnt_d  = cfg_data_i[8:0];
        CFG_TRIG_CODE:  tcode_d = cfg_data_i[7:0];
        CFG_TRIG_MAGIC: magic_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      ST_CLEAR: begin
        hs_we = (32'(clr_q) < HOLDING_DEPTH);
        hs_wa = clr_q[HAW-1:0];
        is_we = (32'(clr_q) < INPUT_DEPTH);
        is_wa = clr_q[IAW-1:0];
        cs_we = (32'(clr_q) < COIL_DEPTH);
        cs_wa = clr_q[CAW-1:0];
        ds_we = (32'(clr_q) < DISCRETE_DEPTH);
        ds_wa = clr_q[DAW-1:0];
        clr_d = clr_q + CLW'(1);
        if (clr_q == CLW'(MAXD - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (operation_i)
            OP_RX_BYTE: begin
              if (rxlen_q < RLW'(FRAME_BYTES)) begin
                rx_we   = 1'b1;
                rx_wa   = rxlen_q[RAW-1:0];
                rx_wd   = rx_byte_i;
                rxlen_d = rxlen_q + RLW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            OP_FRAME_END: begin
              n_d     = rxlen_q;
              rxlen_d = '0;
              ovf_d   = 1'b0;
              if (ovf_q) begin
                err_d = err_q + 16'd1;
              end else if (rxlen_q == '0) begin
                state_d = ST_IDLE;
              end else if (rxlen_q < RLW'(6)) begin
                err_d = err_q + 16'd1;
              end else begin
                // read at least eight bytes: a coil write echoes bytes 6 and 7
                state_d = ST_SCAN;
                ri_d    = '0;
                rend_d  = (rxlen_q < RLW'(8)) ? RLW'(8) : rxlen_q;
                crc_d   = CRC_INIT;
              end
            end
            OP_LOAD_INPUT: begin
              is_we = (32'(local_address_i) < INPUT_DEPTH);
              is_wa = IAW'(local_address_i);
              is_wd = local_value_i;
            end
            OP_LOAD_DISC: begin
              ds_we = (32'(local_address_i) < DISCRETE_DEPTH);
              ds_wa = DAW'(local_address_i);
              ds_wd = local_value_i[0];
            end
            OP_READ_HOLD: begin
              hv_d    = (32'(local_address_i) < HOLDING_DEPTH);
              hsel_d  = 1'b0;
              hs_re   = 1'b1;
              hs_ra   = HAW'(local_address_i);
              state_d = ST_HREAD;
            end
            OP_READ_COIL: begin
              hv_d    = (32'(local_address_i) < COIL_DEPTH);
              hsel_d  = 1'b1;
              cs_re   = 1'b1;
              cs_ra   = CAW'(local_address_i);
              state_d = ST_HREAD;
            end
            default: ;
          endcase
        end
      end
      ST_HREAD: begin
        hr.valid = 1'b1;
        hr.value = !hv_q ? 16'h0000 : (hsel_q ? {15'h0000, cs_rd} : hs_rd);
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (ri_q < rend_q) begin
          rx_re = 1'b1;
          rx_ra = ri_q[RAW-1:0];
          ri_d  = ri_q + RLW'(1);
          pv_d  = 1'b1;
        end
        if (pv_q) begin
          if (pj_q < n_q - RLW'(2)) begin
            crc_d = crc_byte(crc_q, rx_rd);
          end
          if (pj_q < RLW'(8)) begin
            f_d[pj_q[2:0]] = rx_rd;
          end
          if (pj_q == n_q - RLW'(2)) begin
            fl2_d = rx_rd;
          end
          if (pj_q == n_q - RLW'(1)) begin
            fl1_d = rx_rd;
          end
          if (pj_q == rend_q - RLW'(1)) begin
            state_d = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        err_d  = err_q + {15'h0000, d_err};
        kind_d = d_kind;
        code_d = d_code;
        nb_d   = nb17[7:0];
        h_d    = 3'd0;
        k_d    = 8'd0;
        c_d    = 1'b0;
        j_d    = 4'd0;
        txcrc_d = CRC_INIT;
        hs_we  = d_holdwr;
        hs_wa  = start16[HAW-1:0];
        hs_wd  = qty16;
        cs_we  = d_coilwr;
        cs_wa  = start16[CAW-1:0];
        cs_wd  = (f_q[4] == COIL_ON);
        if (d_wr16 && qty16 != 16'h0000) begin
          state_d = ST_WR16;
          ri_d    = RLW'(7);
          rend_d  = n_q - RLW'(2);
        end else if (d_kind == RSP_NONE) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_HDR;
        end
      end
      ST_WR16: begin
        if (ri_q < rend_q) begin
          rx_re = 1'b1;
          rx_ra = ri_q[RAW-1:0];
          ri_d  = ri_q + RLW'(1);
          pv_d  = 1'b1;
        end
        if (pv_q) begin
          if (!rel[0]) begin
            hi_d = rx_rd;
          end else begin
            hs_we = 1'b1;
            hs_wa = HAW'(start16 + 16'(rel >> 1));
            hs_wd = {hi_q, rx_rd};
          end
          if (pj_q == rend_q - RLW'(1)) begin
            state_d = (kind_q == RSP_NONE) ? ST_IDLE : ST_HDR;
          end
        end
      end
      ST_HDR: begin
        if (tx_acc) begin
          txcrc_d = crc_byte(txcrc_q, hbyte);
          h_d     = h_q + 3'd1;
          if (h_q == hlen) begin
            case (kind_q)
              RSP_ECHO8: state_d = ST_IDLE;
              RSP_RREGS: state_d = (qty16 == 16'h0000) ? ST_TXCRC : ST_RRD;
              RSP_RBITS: state_d = ST_BRD;
              default:   state_d = ST_TXCRC;
            endcase
          end
        end
      end
      ST_RRD: begin
        if (f_q[1] == FN_RD_HOLD) begin
          hs_re = 1'b1;
          hs_ra = HAW'(start16 + {8'h00, k_q});
        end else begin
          is_re = 1'b1;
          is_ra = IAW'(start16 + {8'h00, k_q});
        end
        state_d = ST_RHI;
      end
      ST_RHI: begin
        if (tx_acc) begin
          txcrc_d = crc_byte(txcrc_q, rreg[15:8]);
          state_d = ST_RLO;
        end
      end
      ST_RLO: begin
        if (tx_acc) begin
          txcrc_d = crc_byte(txcrc_q, rreg[7:0]);
          k_d     = k_q + 8'd1;
          state_d = ({8'h00, k_q + 8'd1} == qty16) ? ST_TXCRC : ST_RRD;
        end
      end
      ST_BRD: begin
        // issue bit j, collect bit j-1 from the previous read
        if (j_q < 4'd8) begin
          bpv_d = (off16 < qty16);
          if (f_q[1] == FN_RD_COILS) begin
            cs_re = (off16 < qty16);
            cs_ra = CAW'(start16 + off16);
          end else begin
            ds_re = (off16 < qty16);
            ds_ra = DAW'(start16 + off16);
          end
        end
        if (j_q != 4'd0) begin
          db_d[3'(j_q - 4'd1)] = bpv_q &&
                                 ((f_q[1] == FN_RD_COILS) ? cs_rd[0] : ds_rd[0]);
        end
        j_d = j_q + 4'd1;
        if (j_q == 4'd8) begin
          state_d = ST_BEMIT;
        end
      end
      ST_BEMIT: begin
        if (tx_acc) begin
          txcrc_d = crc_byte(txcrc_q, db_q);
          k_d     = k_q + 8'd1;
          j_d     = 4'd0;
          state_d = ((k_q + 8'd1) == nb_q) ? ST_TXCRC : ST_BRD;
        end
      end
      ST_TXCRC: begin
        if (tx_acc) begin
          c_d = 1'b1;
          if (c_q) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      sa_q    <= 8'd1;
      tcode_q <= 8'd65;
      hcnt_q  <= '0;
      icnt_q  <= '0;
      ccnt_q  <= '0;
      dcnt_q  <= '0;
      magic_q <= '0;
      rxlen_q <= '0;
      ovf_q   <= 1'b0;
      err_q   <= '0;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      sa_q    <= sa_d;
      tcode_q <= tcode_d;
      hcnt_q  <= hcnt_d;
      icnt_q  <= icnt_d;
      ccnt_q  <= ccnt_d;
      dcnt_q  <= dcnt_d;
      magic_q <= magic_d;
      rxlen_q <= rxlen_d;
      ovf_q   <= ovf_d;
      err_q   <= err_d;
      pv_q    <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    ri_q    <= ri_d;
    rend_q  <= rend_d;
    pj_q    <= pj_d;
    crc_q   <= crc_d;
    txcrc_q <= txcrc_d;
    f_q     <= f_d;
    fl2_q   <= fl2_d;
    fl1_q   <= fl1_d;
    kind_q  <= kind_d;
    code_q  <= code_d;
    hv_q    <= hv_d;
    hsel_q  <= hsel_d;
    h_q     <= h_d;
    k_q     <= k_d;
    nb_q    <= nb_d;
    db_q    <= db_d;
    hi_q    <= hi_d;
    j_q     <= j_d;
    bpv_q   <= bpv_d;
    c_q     <= c_d;
  end

  assign cfg_ready_o = 1'b1;

  mbrtu_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_rx_buf (
    .clk_i, .we_i(rx_we), .waddr_i(rx_wa), .wdata_i(rx_wd),
    .re_i(rx_re), .raddr_i(rx_ra), .rdata_o(rx_rd)
  );

  mbrtu_ram #(.WIDTH(16), .DEPTH(HOLDING_DEPTH)) u_hold (
    .clk_i, .we_i(hs_we), .waddr_i(hs_wa), .wdata_i(hs_wd),
    .re_i(hs_re), .raddr_i(hs_ra), .rdata_o(hs_rd)
  );

  mbrtu_ram #(.WIDTH(16), .DEPTH(INPUT_DEPTH)) u_input (
    .clk_i, .we_i(is_we), .waddr_i(is_wa), .wdata_i(is_wd),
    .re_i(is_re), .raddr_i(is_ra), .rdata_o(is_rd)
  );

  mbrtu_ram #(.WIDTH(1), .DEPTH(COIL_DEPTH)) u_coil (
    .clk_i, .we_i(cs_we), .waddr_i(cs_wa), .wdata_i(cs_wd),
    .re_i(cs_re), .raddr_i(cs_ra), .rdata_o(cs_rd)
  );

  mbrtu_ram #(.WIDTH(1), .DEPTH(DISCRETE_DEPTH)) u_disc (
    .clk_i, .we_i(ds_we), .waddr_i(ds_wa), .wdata_i(ds_wd),
    .re_i(ds_re), .raddr_i(ds_ra), .rdata_o(ds_rd)
  );

  mbrtu_txpack u_txpack (
    .clk_i,
    .rst_ni,
    .byte_i               (tb),
    .host_i               (hr),
    .err_i                (err_q),
    .slot_free_o          (slot_free),
    .out_valid_o,
    .out_ready_i,
    .tx_word_o,
    .tx_count_o,
    .tx_last_o,
    .host_read_value_o,
    .error_total_o,
    .bootloader_request_o
  );

endmodule
`default_nettype wire
